[design/tsi_pkg.sv]
// Shared constants, status codes and controller/datapath interface types.
package tsi_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int MAX_DIVISIONS = 65535;

    localparam int BOUND_W   = 24;
    localparam int DIVS_W    = 16;
    localparam int INT_W     = 48;
    localparam int STAT_W    = 2;
    localparam int HQ_FRAC   = 32;
    localparam int HQ_W      = BOUND_W + HQ_FRAC;
    localparam int X_W       = BOUND_W + 2;
    localparam int SQ_W      = 2 * BOUND_W;
    localparam int TOT_W     = 64;
    localparam int LIMB_W    = 32;
    localparam int PROD_W    = HQ_W + TOT_W;
    localparam int RND_SHIFT = 2 * FRAC_BITS + 33;

    localparam logic [INT_W-1:0] INTEGRAL_MAX = {1'b0, {(INT_W-1){1'b1}}};

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO_DIV = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_ASC  = 2'd2;
    localparam logic [STAT_W-1:0] ST_SAT      = 2'd3;

    typedef struct packed {
        logic              latch;
        logic              div_start;
        logic              end_a;
        logic              end_b;
        logic              step;
        logic              mul_go;
        logic [1:0]        mul_idx;
        logic              rnd;
        logic              load_out;
        logic [STAT_W-1:0] out_code;
    } t_dp_cmd;

    typedef struct packed {
        logic              n_zero;
        logic              not_asc;
        logic              div_done;
        logic [DIVS_W-1:0] n_cl;
    } t_dp_status;

endpackage

[design/trapezoid_square_integrator.sv]
// Top level: trapezoid-rule integral of x squared, one item at a time.
// The inner-point loop handles one point per cycle, and the step divider builds the
// 56-bit step one quotient bit per cycle.
// Bad requests (zero divisions, bounds not ascending) report from the check state, before any divide.
// Throughput: one item in flight; busy is high from the cycle after accept until o_valid.
// Synchronous active-low reset returns the controller to idle; o_valid is low after reset.
module trapezoid_square_integrator import tsi_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [BOUND_W-1:0] i_lower_bound,
    input  logic signed [BOUND_W-1:0] i_upper_bound,
    input  logic [DIVS_W-1:0]         i_divisions,
    output logic                      o_valid,
    output logic signed [INT_W-1:0]   o_integral,
    output logic [STAT_W-1:0]         o_status
);

    t_dp_cmd    cmd;
    t_dp_status flags;

    tsi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_flags (flags),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    tsi_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_lower_bound  (i_lower_bound),
        .i_upper_bound  (i_upper_bound),
        .i_divisions    (i_divisions),
        .o_status_flags (flags),
        .o_integral     (o_integral),
        .o_status       (o_status)
    );

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_SAT) |-> (o_integral == INTEGRAL_MAX))
        else $error("saturated status without the limit value");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_ZERO_DIV || o_status == ST_NOT_ASC))
        |-> (o_integral == '0))
        else $error("error status with a nonzero integral");

endmodule

[design/tsi_div.sv]
// Restoring divider, one quotient bit per cycle: step = (b - a) << 32 / n.
module tsi_div import tsi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [HQ_W-1:0]   i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_done,
    output logic [HQ_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2(HQ_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W-1:0] r_div;
    logic [HQ_W-1:0]   r_q;

    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              ge;
    logic [DIVS_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_q[HQ_W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
        n_rem = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_q    <= i_dividend;
            end else if (r_busy) begin
                // dividend shifts out the top as quotient bits shift in
                r_q   <= {r_q[HQ_W-2:0], ge};
                r_rem <= n_rem;
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(HQ_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[design/tsi_datapath.sv]
// Datapath: operand latch, step divider, point/square/sum pipeline, limb multiply, round, saturate.
module tsi_datapath import tsi_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  logic signed [BOUND_W-1:0] i_lower_bound,
    input  logic signed [BOUND_W-1:0] i_upper_bound,
    input  logic [DIVS_W-1:0]         i_divisions,
    output t_dp_status                o_status_flags,
    output logic signed [INT_W-1:0]   o_integral,
    output logic [STAT_W-1:0]         o_status
);

    localparam logic [HQ_W:0] HALF_LSB = (HQ_W+1)'(64'h8000_0000);
    localparam int RES_HI_W = PROD_W - (RND_SHIFT + INT_W - 1);

    logic signed [BOUND_W-1:0] r_a;
    logic signed [BOUND_W-1:0] r_b;
    logic [DIVS_W-1:0]         r_n;

    logic [HQ_W-1:0]     r_acc;
    logic                r_va;
    logic [X_W-1:0]      r_x;
    logic                r_vb;
    logic                r_db;
    logic [SQ_W-1:0]     r_sq;
    logic                r_vs;
    logic                r_ds;
    logic [TOT_W-1:0]    r_total;
    logic [2*LIMB_W-1:0] r_pp;
    logic [1:0]          r_pp_sh;
    logic                r_ppv;
    logic [PROD_W-1:0]   r_prod;
    logic [PROD_W-1:0]   r_rnd;
    logic [INT_W-1:0]    r_int;
    logic [STAT_W-1:0]   r_stat;

    logic [DIVS_W-1:0]   n_cl;
    logic [BOUND_W:0]    span;
    logic                div_done;
    logic [HQ_W-1:0]     hq;
    logic [HQ_W:0]       acc_rnd;
    logic [X_W-1:0]      x_inner;
    logic [X_W-1:0]      x_abs;
    logic [BOUND_W-1:0]  mag;
    logic [LIMB_W-1:0]   l_hq;
    logic [LIMB_W-1:0]   l_tot;
    logic [TOT_W-1:0]    sq_add;
    logic [PROD_W-1:0]   pp_add;
    logic [RES_HI_W-1:0] res_hi;
    logic [INT_W-2:0]    res_lo;

    always_comb begin
        n_cl = (32'(r_n) > MAX_DIVISIONS) ? DIVS_W'(MAX_DIVISIONS) : r_n;
        span = {r_b[BOUND_W-1], r_b} - {r_a[BOUND_W-1], r_a};
    end

    tsi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({span[BOUND_W-1:0], {HQ_FRAC{1'b0}}}),
        .i_divisor  (n_cl),
        .o_done     (div_done),
        .o_quot     (hq)
    );

    always_comb begin
        // inner point = a + round-to-nearest(acc at input resolution)
        acc_rnd = {1'b0, r_acc} + HALF_LSB;
        x_inner = {{(X_W-BOUND_W){r_a[BOUND_W-1]}}, r_a}
                + X_W'(acc_rnd[HQ_W:HQ_FRAC]);
        x_abs   = r_x[X_W-1] ? (~r_x + X_W'(1)) : r_x;
        // points stay inside [a, b], so the magnitude fits the bound width
        mag     = x_abs[BOUND_W-1:0];
        sq_add  = r_ds ? TOT_W'({r_sq, 1'b0}) : TOT_W'(r_sq);
        l_hq    = i_cmd.mul_idx[0] ? LIMB_W'(hq[HQ_W-1:LIMB_W]) : hq[LIMB_W-1:0];
        l_tot   = i_cmd.mul_idx[1] ? r_total[TOT_W-1:LIMB_W] : r_total[LIMB_W-1:0];
        case (r_pp_sh)
            2'd0:    pp_add = PROD_W'(r_pp);
            2'd1:    pp_add = PROD_W'(r_pp) << LIMB_W;
            2'd2:    pp_add = PROD_W'(r_pp) << (2 * LIMB_W);
            default: pp_add = '0;
        endcase
        res_hi = r_rnd[PROD_W-1:RND_SHIFT+INT_W-1];
        res_lo = r_rnd[RND_SHIFT+INT_W-2:RND_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va  <= 1'b0;
            r_vb  <= 1'b0;
            r_vs  <= 1'b0;
            r_ppv <= 1'b0;
        end else begin
            r_va  <= i_cmd.step;
            r_vb  <= r_va | i_cmd.end_a | i_cmd.end_b;
            r_vs  <= r_vb;
            r_ppv <= i_cmd.mul_go;
        end

        if (i_cmd.latch) begin
            r_a <= i_lower_bound;
            r_b <= i_upper_bound;
            r_n <= i_divisions;
        end

        if (i_cmd.latch) begin
            r_acc <= '0;
        end else if (i_cmd.step) begin
            r_acc <= r_acc + hq;
        end

        if (r_va) begin
            r_x  <= x_inner;
            r_db <= 1'b1;
        end else if (i_cmd.end_a) begin
            r_x  <= {{(X_W-BOUND_W){r_a[BOUND_W-1]}}, r_a};
            r_db <= 1'b0;
        end else begin
            r_x  <= {{(X_W-BOUND_W){r_b[BOUND_W-1]}}, r_b};
            r_db <= 1'b0;
        end

        r_sq <= SQ_W'(mag) * SQ_W'(mag);
        r_ds <= r_db;

        // inner squares count twice, end squares once
        if (i_cmd.latch) begin
            r_total <= '0;
        end else if (r_vs) begin
            r_total <= r_total + sq_add;
        end

        r_pp    <= (2*LIMB_W)'(l_hq) * (2*LIMB_W)'(l_tot);
        r_pp_sh <= 2'(i_cmd.mul_idx[0]) + 2'(i_cmd.mul_idx[1]);

        if (i_cmd.latch) begin
            r_prod <= '0;
        end else if (r_ppv) begin
            r_prod <= r_prod + pp_add;
        end

        if (i_cmd.rnd) begin
            r_rnd <= r_prod + (PROD_W'(1) << (RND_SHIFT - 1));
        end

        if (i_cmd.load_out) begin
            if (i_cmd.out_code == ST_OK) begin
                if (res_hi != '0) begin
                    r_int  <= INTEGRAL_MAX;
                    r_stat <= ST_SAT;
                end else begin
                    r_int  <= {1'b0, res_lo};
                    r_stat <= ST_OK;
                end
            end else begin
                r_int  <= '0;
                r_stat <= i_cmd.out_code;
            end
        end
    end

    assign o_status_flags.n_zero   = (n_cl == '0);
    assign o_status_flags.not_asc  = (r_b <= r_a);
    assign o_status_flags.div_done = div_done;
    assign o_status_flags.n_cl     = n_cl;
    assign o_integral              = r_int;
    assign o_status                = r_stat;

endmodule

[design/tsi_ctrl.sv]
// Controller: sequences check, divide, end points, inner points, multiply and output.
module tsi_ctrl import tsi_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_flags,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_valid
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_END_A,
        S_END_B,
        S_INNER,
        S_DRAIN,
        S_MUL,
        S_MACC,
        S_RND,
        S_OUT
    } t_state;

    localparam logic [DIVS_W-1:0] DRAIN_CYC = DIVS_W'(2);

    t_state            r_state, n_state;
    logic [DIVS_W-1:0] r_cnt, n_cnt;
    logic              r_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_flags.n_zero) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_code = ST_ZERO_DIV;
                    n_state        = S_IDLE;
                end else if (i_flags.not_asc) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_code = ST_NOT_ASC;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_flags.div_done) begin
                    n_state = S_END_A;
                end
            end
            S_END_A: begin
                o_cmd.end_a = 1'b1;
                n_state     = S_END_B;
            end
            S_END_B: begin
                o_cmd.end_b = 1'b1;
                n_cnt       = i_flags.n_cl - DIVS_W'(1);
                n_state     = S_INNER;
            end
            S_INNER: begin
                if (r_cnt == '0) begin
                    n_cnt   = DRAIN_CYC;
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.step = 1'b1;
                    n_cnt      = r_cnt - DIVS_W'(1);
                end
            end
            S_DRAIN: begin
                // let the point/square/sum pipeline empty
                if (r_cnt == '0) begin
                    n_state = S_MUL;
                end else begin
                    n_cnt = r_cnt - DIVS_W'(1);
                end
            end
            S_MUL: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_idx = r_cnt[1:0];
                if (r_cnt[1:0] == 2'd3) begin
                    n_cnt   = '0;
                    n_state = S_MACC;
                end else begin
                    n_cnt = r_cnt + DIVS_W'(1);
                end
            end
            S_MACC: begin
                n_state = S_RND;
            end
            S_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                o_cmd.load_out = 1'b1;
                o_cmd.out_code = ST_OK;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= o_cmd.load_out;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

[test/square_integral_checker.sv]
// Checker for the trapezoid integrator: predicts each accepted item's result and compares.
module square_integral_checker import tsi_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  logic signed [BOUND_W-1:0] i_lower_bound,
    input  logic signed [BOUND_W-1:0] i_upper_bound,
    input  logic [DIVS_W-1:0]         i_divisions,
    input  logic                      i_valid,
    input  logic signed [INT_W-1:0]   i_integral,
    input  logic [STAT_W-1:0]         i_status,
    output int                        o_mismatches,
    output int                        o_pending
);

    // step carries 32 fraction bits below input resolution, squares 2F, plus one for halving
    localparam int ROUND_SHIFT = 2 * FRAC_BITS + 33;

    typedef struct packed {
        logic [INT_W-1:0]  integral;
        logic [STAT_W-1:0] status;
    } t_estimate;

    t_estimate expected_q[$];
    t_estimate want;
    int        mismatch_cnt = 0;
    int        pending_cnt  = 0;

    assign o_mismatches = mismatch_cnt;
    assign o_pending    = pending_cnt;

    function automatic logic [63:0] square_of(longint signed x);
        logic [63:0] mag;
        mag = (x < 0) ? -x : x;
        return mag * mag;
    endfunction

    function automatic t_estimate trapezoid_estimate(logic signed [BOUND_W-1:0] lo,
                                                     logic signed [BOUND_W-1:0] hi,
                                                     logic [DIVS_W-1:0] divs);
        t_estimate    est;
        longint signed a, b, x;
        logic [63:0]  n, span, step_q, acc, sum_sq;
        logic [127:0] prod;
        a = longint'(lo);
        b = longint'(hi);
        n = 64'(divs);
        if (n > MAX_DIVISIONS)
            n = 64'(MAX_DIVISIONS);
        est.integral = '0;
        if (n == 0) begin
            est.status = ST_ZERO_DIV;
            return est;
        end
        if (b <= a) begin
            est.status = ST_NOT_ASC;
            return est;
        end
        span   = b - a;
        step_q = (span << 32) / n;
        acc    = '0;
        sum_sq = '0;
        // inner points: running sum of the step, rounded to nearest at input resolution
        for (int i = 1; i < n; i++) begin
            acc    = acc + step_q;
            x      = a + longint'((acc + 64'h8000_0000) >> 32);
            sum_sq = sum_sq + square_of(x);
        end
        sum_sq = 2 * sum_sq + square_of(a) + square_of(b);
        prod   = 128'(step_q) * 128'(sum_sq);
        prod   = (prod + (128'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
        if (prod > INTEGRAL_MAX) begin
            est.integral = INTEGRAL_MAX;
            est.status   = ST_SAT;
        end else begin
            est.integral = prod[INT_W-1:0];
            est.status   = ST_OK;
        end
        return est;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_cnt++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result with no item pending: integral %0h status %0d",
                                              i_integral, i_status));
                end else begin
                    want = expected_q.pop_front();
                    if (i_integral !== want.integral)
                        report_mismatch($sformatf("integral %0h, expected %0h",
                                                  i_integral, want.integral));
                    if (i_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_status, want.status));
                end
            end
            if (i_start && !i_busy)
                expected_q.push_back(trapezoid_estimate(i_lower_bound, i_upper_bound,
                                                        i_divisions));
            pending_cnt <= expected_q.size();
        end
    end

endmodule

[test/tb.sv]
// Testbench top: drives directed and random integration requests and gives the verdict.
module tb import tsi_pkg::*;;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int RANDOM_ITEMS   = 82;
    localparam int QUIET_TAIL     = 20;
    localparam int DRAIN_CYCLES   = 100;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic signed [BOUND_W-1:0] i_lower_bound;
    logic signed [BOUND_W-1:0] i_upper_bound;
    logic [DIVS_W-1:0]         i_divisions;
    logic                      o_valid;
    logic signed [INT_W-1:0]   o_integral;
    logic [STAT_W-1:0]         o_status;
    int                        mismatches;
    int                        pending;
    int                        stalled_cycles = 0;

    always #5 i_clk = ~i_clk;

    trapezoid_square_integrator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_lower_bound (i_lower_bound),
        .i_upper_bound (i_upper_bound),
        .i_divisions   (i_divisions),
        .o_valid       (o_valid),
        .o_integral    (o_integral),
        .o_status      (o_status)
    );

    square_integral_checker i_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_lower_bound (i_lower_bound),
        .i_upper_bound (i_upper_bound),
        .i_divisions   (i_divisions),
        .i_valid       (o_valid),
        .i_integral    (o_integral),
        .i_status      (o_status),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // a run at maximum divisions goes without a handshake until its result comes out
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    function automatic int idle_burst();
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 18) : 0;
    endfunction

    task automatic issue(input logic [BOUND_W-1:0] lo, input logic [BOUND_W-1:0] hi,
                         input logic [DIVS_W-1:0] divs, input bit quiet);
        int gap;
        i_lower_bound <= lo;
        i_upper_bound <= hi;
        i_divisions   <= divs;
        start         <= 1'b1;
        do @(posedge i_clk); while (!(start && !busy));
        gap = quiet ? 0 : idle_burst();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // bounds are drawn in offset binary so ordering is easy, then flipped to two's complement
    task automatic random_item(output logic [BOUND_W-1:0] lo, output logic [BOUND_W-1:0] hi,
                               output logic [DIVS_W-1:0] divs);
        int unsigned ua, ub, pick, tier;
        pick = $urandom_range(0, 23);
        if (pick == 0) begin
            ua   = $urandom_range(0, 24'hFFFFFF);
            ub   = $urandom;
            divs = '0;
        end else if (pick == 1) begin
            ua   = $urandom_range(0, 24'hFFFFFF);
            ub   = $urandom_range(0, ua);
            divs = DIVS_W'($urandom);
        end else begin
            ua = $urandom_range(0, 24'hFFFFFE);
            if ($urandom_range(0, 3) == 0) begin
                ub = ua + $urandom_range(1, 300);
                if (ub > 24'hFFFFFF)
                    ub = 24'hFFFFFF;
            end else begin
                ub = $urandom_range(ua + 1, 24'hFFFFFF);
            end
            tier = $urandom_range(0, 19);
            if (tier < 14)
                divs = DIVS_W'($urandom_range(1, 32));
            else if (tier < 19)
                divs = DIVS_W'($urandom_range(33, 600));
            else
                divs = DIVS_W'($urandom_range(601, 65535));
        end
        lo = ua[BOUND_W-1:0] ^ 24'h800000;
        hi = ub[BOUND_W-1:0] ^ 24'h800000;
    endtask

    initial begin
        logic [BOUND_W-1:0] lo, hi;
        logic [DIVS_W-1:0]  divs;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_lower_bound <= '0;
        i_upper_bound <= '0;
        i_divisions   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero divisions wins over the bounds check
        issue(24'h000000, 24'h010000, 16'h0000, 1'b0);
        issue(24'h7FFFFF, 24'h800000, 16'h0000, 1'b0);
        issue(24'h000000, 24'h000000, 16'h0000, 1'b0);
        // equal and descending bounds
        issue(24'h012345, 24'h012345, 16'h0007, 1'b0);
        issue(24'h7FFFFF, 24'h800000, 16'h0001, 1'b0);
        // full span, one and two divisions, then the maximum
        issue(24'h800000, 24'h7FFFFF, 16'h0001, 1'b0);
        issue(24'h800000, 24'h7FFFFF, 16'h0002, 1'b0);
        issue(24'h800000, 24'h7FFFFF, 16'hFFFF, 1'b0);
        // one LSB wide interval split as finely as allowed
        issue(24'h000000, 24'h000001, 16'hFFFF, 1'b0);
        issue(24'h7FFFFE, 24'h7FFFFF, 16'h0001, 1'b0);
        issue(24'hFFFFFF, 24'h000000, 16'h0002, 1'b0);
        issue(24'h800000, 24'h800001, 16'h0003, 1'b0);
        issue(24'hFF0000, 24'h010000, 16'h0004, 1'b0);
        issue(24'h000000, 24'h030000, 16'h0003, 1'b0);
        issue(24'hFFFFFF, 24'h000001, 16'h00FF, 1'b0);
        issue(24'h800000, 24'hFFFFFF, 16'h0100, 1'b0);
        issue(24'h400000, 24'h7FFFFF, 16'h8000, 1'b0);
        issue(24'hABCDEF, 24'h543210, 16'h5555, 1'b0);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            random_item(lo, hi, divs);
            issue(lo, hi, divs, k >= RANDOM_ITEMS - QUIET_TAIL);
            if (k == RANDOM_ITEMS / 2) begin
                start <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
        end
        start <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
